@@ rtl/maft_pkg.sv @@
package maft_pkg;

  // table size and derived widths
  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int CmpW       = (CntW > 5) ? CntW : 5;

  // fixed field widths
  localparam int CmdW    = 3;
  localparam int SlotW   = 4;
  localparam int AddrW   = 16;
  localparam int StatW   = 2;
  localparam int OutIdxW = 4;
  localparam int OutCntW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_CHECK  = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // one filter entry
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] mask;
    logic             act;
    logic             en;
  } entry_t;

  // item token that walks down the row of cells
  typedef struct packed {
    logic            valid;
    cmd_e            cmd;
    logic [SlotW-1:0] slot;
    entry_t          data;
    logic [CntW-1:0] count;
    logic            hit;
    logic            hit_act;
    logic [IdxW-1:0] hit_index;
    entry_t          rd;
  } tok_t;

endpackage

@@ rtl/maft_cell.sv @@
module maft_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [maft_pkg::IdxW-1:0]  index_i,
  input  maft_pkg::tok_t             tok_i,
  input  maft_pkg::entry_t           next_entry_i,
  output maft_pkg::entry_t           entry_o,
  output maft_pkg::tok_t             tok_o
);

  maft_pkg::entry_t entry_q, entry_d;
  maft_pkg::tok_t   tok_q, tok_d;

  logic [maft_pkg::CmpW-1:0] idx_c;
  logic [maft_pkg::CmpW-1:0] slot_c;
  logic [maft_pkg::CmpW-1:0] cnt_c;
  logic                      in_range;
  logic                      match;

  // position compares against the slot and the entry count
  assign idx_c    = maft_pkg::CmpW'(index_i);
  assign slot_c   = maft_pkg::CmpW'(tok_i.slot);
  assign cnt_c    = maft_pkg::CmpW'(tok_i.count);
  assign in_range = slot_c < cnt_c;

  // masked address match for lookups
  assign match = entry_q.en &&
                 ((entry_q.addr & entry_q.mask) == (tok_i.data.addr & entry_q.mask));

  // act on the item as it passes this position
  always_comb begin
    entry_d = entry_q;
    tok_d   = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.cmd)
        maft_pkg::CMD_APPEND: begin
          if (idx_c == cnt_c) entry_d = tok_i.data;
        end
        maft_pkg::CMD_REMOVE: begin
          // this and every later position takes its right neighbor; the last position keeps its own entry
          if (in_range && (idx_c >= slot_c)) entry_d = next_entry_i;
        end
        maft_pkg::CMD_UPDATE: begin
          if (in_range && (idx_c == slot_c)) entry_d = tok_i.data;
        end
        maft_pkg::CMD_READ: begin
          if (in_range && (idx_c == slot_c)) tok_d.rd = entry_q;
        end
        maft_pkg::CMD_CHECK: begin
          // first enabled match wins
          if ((idx_c < cnt_c) && match && !tok_i.hit) begin
            tok_d.hit       = 1'b1;
            tok_d.hit_act   = entry_q.act;
            tok_d.hit_index = index_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign tok_o   = tok_q;

endmodule

@@ rtl/masked_address_filter_table.sv @@
// channel   direction  signals                                   handshake
// command   in         command_i slot_i group_address_i ...      start & !busy
// result    out        status_o verdict_o hit_o ... entry_count_o done_o, one cycle
// config    in         cfg_wdata_i                               cfg_we_i
//
// at accept the item is held in the launch register before it enters the first cell;
// the item walks the row of cells one position per cycle, then the result is registered.
// busy is high from the accept edge until done_o rises; a new item may start in the
// done_o cycle. the receiver cannot stall; done_o is high for one cycle, results stay until the next.
// reset clears the entry count, the default action and all control; entries are
// not cleared and are reachable only once written.
module masked_address_filter_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [maft_pkg::CmdW-1:0]     command_i,
  input  logic [maft_pkg::SlotW-1:0]    slot_i,
  input  logic [maft_pkg::AddrW-1:0]    group_address_i,
  input  logic [maft_pkg::AddrW-1:0]    address_mask_i,
  input  logic                          action_bit_i,
  input  logic                          enable_bit_i,
  output logic                          done_o,
  output logic [maft_pkg::StatW-1:0]    status_o,
  output logic                          verdict_o,
  output logic                          hit_o,
  output logic [maft_pkg::OutIdxW-1:0]  entry_index_o,
  output logic [maft_pkg::AddrW-1:0]    read_address_o,
  output logic [maft_pkg::AddrW-1:0]    read_mask_o,
  output logic                          read_action_o,
  output logic                          read_enable_o,
  output logic [maft_pkg::OutCntW-1:0]  entry_count_o
);

  maft_pkg::state_e  state_q, state_d;
  maft_pkg::status_e status_q, status_d;
  maft_pkg::tok_t    launch_q, launch_d;
  maft_pkg::tok_t    fin_tok;
  maft_pkg::cmd_e    cmd;

  logic [maft_pkg::CntW-1:0] count_q, count_d;
  logic                      default_q;
  logic                      accept;
  logic                      finish;
  logic [maft_pkg::CmpW-1:0] cnt_c;
  logic [maft_pkg::CmpW-1:0] slot_c;
  logic [maft_pkg::CmpW-1:0] idx_ext;
  logic [maft_pkg::CmpW-1:0] cnt_ext;

  logic                          done_q;
  logic [maft_pkg::StatW-1:0]    status_out_q;
  logic                          verdict_q;
  logic                          hit_q;
  logic [maft_pkg::OutIdxW-1:0]  entry_index_q;
  maft_pkg::entry_t              rd_q;
  logic [maft_pkg::OutCntW-1:0]  entry_count_q;

  maft_pkg::tok_t   tok [maft_pkg::TableDepth+1];
  maft_pkg::entry_t ent [maft_pkg::TableDepth];

  assign accept = start && (state_q == maft_pkg::ST_IDLE);
  assign busy   = (state_q != maft_pkg::ST_IDLE);
  assign cmd    = maft_pkg::cmd_e'(command_i);
  assign cnt_c  = maft_pkg::CmpW'(count_q);
  assign slot_c = maft_pkg::CmpW'(slot_i);

  // status and new count are known at accept
  always_comb begin
    count_d  = count_q;
    status_d = maft_pkg::STAT_OK;
    unique case (cmd)
      maft_pkg::CMD_APPEND: begin
        if (cnt_c >= maft_pkg::CmpW'(maft_pkg::TableDepth)) status_d = maft_pkg::STAT_FULL;
        else count_d = count_q + 1'b1;
      end
      maft_pkg::CMD_REMOVE: begin
        if (slot_c >= cnt_c) status_d = maft_pkg::STAT_RANGE;
        else count_d = count_q - 1'b1;
      end
      maft_pkg::CMD_UPDATE, maft_pkg::CMD_READ: begin
        if (slot_c >= cnt_c) status_d = maft_pkg::STAT_RANGE;
      end
      maft_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // token that enters the first cell
  always_comb begin
    launch_d           = '0;
    launch_d.valid     = accept;
    launch_d.cmd       = cmd;
    launch_d.slot      = slot_i;
    launch_d.data.addr = group_address_i;
    launch_d.data.mask = address_mask_i;
    launch_d.data.act  = action_bit_i;
    launch_d.data.en   = enable_bit_i;
    launch_d.count     = count_q;
  end

  // row of cells, one entry each
  assign tok[0] = launch_q;

  for (genvar g = 0; g < maft_pkg::TableDepth; g++) begin : g_cell
    maft_pkg::entry_t next_entry;
    if (g == maft_pkg::TableDepth - 1) begin : g_last
      assign next_entry = ent[g];
    end else begin : g_mid
      assign next_entry = ent[g+1];
    end
    maft_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .index_i      (maft_pkg::IdxW'(g)),
      .tok_i        (tok[g]),
      .next_entry_i (next_entry),
      .entry_o      (ent[g]),
      .tok_o        (tok[g+1])
    );
  end

  assign fin_tok = tok[maft_pkg::TableDepth];
  assign finish  = fin_tok.valid;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      maft_pkg::ST_IDLE: begin
        if (start) state_d = maft_pkg::ST_SCAN;
      end
      maft_pkg::ST_SCAN: begin
        if (finish) state_d = maft_pkg::ST_IDLE;
      end
      default: state_d = maft_pkg::ST_IDLE;
    endcase
  end

  // result index: appended position or first matching position
  always_comb begin
    idx_ext = '0;
    if ((fin_tok.cmd == maft_pkg::CMD_APPEND) && (status_q == maft_pkg::STAT_OK)) begin
      idx_ext = maft_pkg::CmpW'(fin_tok.count);
    end else if ((fin_tok.cmd == maft_pkg::CMD_CHECK) && fin_tok.hit) begin
      idx_ext = maft_pkg::CmpW'(fin_tok.hit_index);
    end
  end

  assign cnt_ext = maft_pkg::CmpW'(count_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= maft_pkg::ST_IDLE;
      count_q   <= '0;
      default_q <= 1'b0;
      launch_q  <= '0;
      status_q  <= maft_pkg::STAT_OK;
      done_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      done_q   <= finish;
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
      if (cfg_we_i) default_q <= cfg_wdata_i;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_out_q  <= status_q;
      verdict_q     <= (fin_tok.cmd == maft_pkg::CMD_CHECK) &&
                       (fin_tok.hit ? fin_tok.hit_act : default_q);
      hit_q         <= (fin_tok.cmd == maft_pkg::CMD_CHECK) && fin_tok.hit;
      entry_index_q <= idx_ext[maft_pkg::OutIdxW-1:0];
      rd_q          <= fin_tok.rd;
      entry_count_q <= cnt_ext[maft_pkg::OutCntW-1:0];
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_out_q;
  assign verdict_o      = verdict_q;
  assign hit_o          = hit_q;
  assign entry_index_o  = entry_index_q;
  assign read_address_o = rd_q.addr;
  assign read_mask_o    = rd_q.mask;
  assign read_action_o  = rd_q.act;
  assign read_enable_o  = rd_q.en;
  assign entry_count_o  = entry_count_q;

endmodule
